// ===== sv/es2c_pkg.sv =====
// Shared types, constants and the month length table for the epoch
// seconds to calendar converter. No dependencies.
package es2c_pkg;

  // Reciprocals for the constant divisions, each rounded up so that
  // (x * RECIP) >> shift is the exact quotient over the operand range:
  // day 2^34 / 675 on secs >> 7, hour 2^21 / 225 on tod >> 4,
  // minute 2^14 / 15 on the hour remainder >> 2
  localparam logic [24:0] RECIP_DAY  = 25'd25451659;
  localparam logic [24:0] RECIP_HOUR = 25'd9321;
  localparam logic [24:0] RECIP_MIN  = 25'd1093;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  localparam logic [10:0] EPOCH_YEAR    = 11'd1970;
  // 1970 mod 100 and 1970 mod 400, for the leap-year rule
  localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
  localparam logic [6:0]  LAST_MOD100   = 7'd99;
  localparam logic [8:0]  LAST_MOD400   = 9'd399;
  localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
  localparam logic [3:0]  DECEMBER      = 4'd11;
  localparam logic [3:0]  FEBRUARY      = 4'd1;

  typedef enum logic [1:0] {
    SEL_DAY  = 2'd0,
    SEL_HOUR = 2'd1,
    SEL_MIN  = 2'd2
  } div_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load_day;
    logic     load_hour;
    logic     load_min;
    logic     div_step;
    div_sel_t div_sel;
    logic     init_year;
    logic     year_step;
    logic     month_step;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  // Days in a month, months counted from 0 (January)
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      FEBRUARY: len = leap ? 5'd29 : 5'd28;
      4'd3:     len = 5'd30;
      4'd5:     len = 5'd30;
      4'd8:     len = 5'd30;
      4'd10:    len = 5'd30;
      default:  len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/es2c_dpath.sv =====
// Datapath of the epoch seconds to calendar converter: shared reciprocal
// divider, weekday residue, year and month walk. Depends on es2c_pkg.
module es2c_dpath (
  input  logic             clk,
  input  es2c_pkg::cmd_t    cmd,
  output es2c_pkg::status_t status,
  input  logic [30:0]      epoch_seconds,
  output logic [4:0]       day_of_month,
  output logic [3:0]       month_number,
  output logic [10:0]      year_number,
  output logic [2:0]       weekday,
  output logic [4:0]       hours,
  output logic [5:0]       minutes,
  output logic [5:0]       seconds_part
);
  import es2c_pkg::*;

  logic [30:0] secs;
  logic [14:0] days;
  logic [16:0] tod;
  logic [11:0] rem;
  logic [2:0]  wd;
  logic [10:0] year;
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic [3:0]  mon;
  logic [4:0]  hh;
  logic [5:0]  mm;
  logic [5:0]  ss;

  logic [23:0] mul_a;
  logic [24:0] mul_b;
  logic [48:0] prod;
  logic [14:0] quo;
  logic [30:0] day_secs;
  logic [30:0] tod_left;
  logic [16:0] hour_secs;
  logic [16:0] min_left;
  logic [16:0] min_secs;
  logic [16:0] sec_left;
  logic [5:0]  oct_sum;
  logic [3:0]  oct_fold;
  logic [2:0]  wd_fold;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mlen;
  logic [3:0]  wd_out;

  // Pick operand and reciprocal; the divisor's power-of-two factor is shifted off first
  always_comb begin
    case (cmd.div_sel)
      SEL_DAY: begin
        mul_a = secs[30:7];
        mul_b = RECIP_DAY;
      end
      SEL_HOUR: begin
        mul_a = {11'b0, tod[16:4]};
        mul_b = RECIP_HOUR;
      end
      SEL_MIN: begin
        mul_a = {14'b0, rem[11:2]};
        mul_b = RECIP_MIN;
      end
      default: begin
        mul_a = secs[30:7];
        mul_b = RECIP_DAY;
      end
    endcase
  end

  assign prod = {25'b0, mul_a} * {24'b0, mul_b};

  // Drop the fraction bits of the product
  always_comb begin
    case (cmd.div_sel)
      SEL_DAY:  quo = prod[48:34];
      SEL_HOUR: quo = {10'b0, prod[25:21]};
      SEL_MIN:  quo = {9'b0, prod[19:14]};
      default:  quo = prod[48:34];
    endcase
  end

  // Remainders: subtract the quotient times its divisor
  assign day_secs  = {16'b0, days} * {14'b0, SECS_PER_DAY};
  assign tod_left  = secs - day_secs;
  assign hour_secs = {12'b0, hh} * SECS_PER_HOUR;
  assign min_left  = tod - hour_secs;
  assign min_secs  = {11'b0, mm} * SECS_PER_MIN;
  assign sec_left  = {5'b0, rem} - min_secs;

  // Day count mod 7 by summing octal digits, since 8 is 1 mod 7
  assign oct_sum  = {3'b0, days[2:0]} + {3'b0, days[5:3]} + {3'b0, days[8:6]}
                  + {3'b0, days[11:9]} + {3'b0, days[14:12]};
  assign oct_fold = {1'b0, oct_sum[2:0]} + {1'b0, oct_sum[5:3]};
  assign wd_fold  = (oct_fold >= 4'd7) ? 3'(oct_fold - 4'd7) : oct_fold[2:0];

  // Leap rule from the year's residues mod 4, 100 and 400
  assign leap     = (year[1:0] == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mlen     = month_len(mon, leap);

  assign status.year_done  = days < {6'b0, year_len};
  assign status.month_done = (mon == DECEMBER) || (days < {10'b0, mlen});

  // Capture the request, each quotient and remainder in turn, then walk years and months
  always_ff @(posedge clk) begin
    if (cmd.load_day) begin
      secs <= epoch_seconds;
    end else if (cmd.div_step) begin
      case (cmd.div_sel)
        SEL_DAY:  days <= quo;
        SEL_HOUR: hh   <= quo[4:0];
        SEL_MIN:  mm   <= quo[5:0];
        default:  days <= quo;
      endcase
    end else if (cmd.load_hour) begin
      tod <= tod_left[16:0];
      wd  <= wd_fold;
    end else if (cmd.load_min) begin
      rem <= min_left[11:0];
    end else if (cmd.init_year) begin
      ss     <= sec_left[5:0];
      year   <= EPOCH_YEAR;
      mod100 <= EPOCH_MOD100;
      mod400 <= EPOCH_MOD400;
      mon    <= 4'd0;
    end else if (cmd.year_step) begin
      days   <= days - {6'b0, year_len};
      year   <= year + 11'd1;
      mod100 <= (mod100 == LAST_MOD100) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == LAST_MOD400) ? 9'd0 : mod400 + 9'd1;
    end else if (cmd.month_step) begin
      days <= days - {10'b0, mlen};
      mon  <= mon + 4'd1;
    end
  end

  // Shift the weekday residue by the epoch's weekday
  assign wd_out = {1'b0, wd} + {1'b0, EPOCH_WEEKDAY};

  assign day_of_month = days[4:0] + 5'd1;
  assign month_number = mon + 4'd1;
  assign year_number  = year;
  assign weekday      = (wd_out >= 4'd7) ? 3'(wd_out - 4'd7) : wd_out[2:0];
  assign hours        = hh;
  assign minutes      = mm;
  assign seconds_part = ss;

endmodule

// ===== sv/es2c_ctrl.sv =====
// Controller of the epoch seconds to calendar converter: sequences the
// division steps and the year and month walk. Depends on es2c_pkg.
module es2c_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output es2c_pkg::cmd_t    cmd,
  input  es2c_pkg::status_t status
);
  import es2c_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_DAY    = 10'b00_0000_0010,
    ST_LOAD_H = 10'b00_0000_0100,
    ST_HOUR   = 10'b00_0000_1000,
    ST_LOAD_M = 10'b00_0001_0000,
    ST_MIN    = 10'b00_0010_0000,
    ST_INIT_Y = 10'b00_0100_0000,
    ST_YEARS  = 10'b00_1000_0000,
    ST_MONTHS = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = SEL_DAY;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load_day = 1'b1;
          state_next   = ST_DAY;
        end
      end
      ST_DAY: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = SEL_DAY;
        state_next   = ST_LOAD_H;
      end
      ST_LOAD_H: begin
        cmd.load_hour = 1'b1;
        state_next    = ST_HOUR;
      end
      ST_HOUR: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = SEL_HOUR;
        state_next   = ST_LOAD_M;
      end
      ST_LOAD_M: begin
        cmd.load_min = 1'b1;
        state_next   = ST_MIN;
      end
      ST_MIN: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = SEL_MIN;
        state_next   = ST_INIT_Y;
      end
      ST_INIT_Y: begin
        cmd.init_year = 1'b1;
        state_next    = ST_YEARS;
      end
      ST_YEARS: begin
        if (status.year_done) begin
          state_next = ST_MONTHS;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      ST_MONTHS: begin
        if (status.month_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

// ===== sv/epoch_seconds_to_calendar.sv =====
// Top level of the epoch seconds to calendar converter: joins the
// controller and the datapath. Depends on es2c_pkg, es2c_ctrl, es2c_dpath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  request  | start, busy          | epoch_seconds
//  result   | done (one cycle)     | day_of_month, month_number, year_number,
//           |                      | weekday, hours, minutes, seconds_part
//
// A request is taken when start is high and busy is low. Done rises after the
// controller has run the day, hour and minute divisions, set up the year walk,
// walked Y whole years past 1970 and then M whole months; Y + M is at most 78.
// The year walk, one year per cycle, dominates. Busy falls the cycle after done,
// so a new request is taken only after the last result is out. Synchronous
// reset returns the controller to idle. The receiver cannot stall.
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [30:0] epoch_seconds,
  output logic [4:0]  day_of_month,
  output logic [3:0]  month_number,
  output logic [10:0] year_number,
  output logic [2:0]  weekday,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds_part
);
  import es2c_pkg::*;

  cmd_t    cmd;
  status_t status;

  es2c_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  es2c_dpath u_dpath (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .epoch_seconds (epoch_seconds),
    .day_of_month  (day_of_month),
    .month_number  (month_number),
    .year_number   (year_number),
    .weekday       (weekday),
    .hours         (hours),
    .minutes       (minutes),
    .seconds_part  (seconds_part)
  );

endmodule
